/* rtl/core/lkvc_pkg.sv */
// lkvc_pkg: shared types and constants for the lru key/value cache core
// transfer payload structs, opcode codes and the per-cell control group
// no dependencies
package lkvc_pkg;

    localparam int LKVC_KEY_W      = 32;
    localparam int LKVC_CAP_W      = 5;
    localparam int LKVC_ENTRIES    = 16;
    // wide enough for any slot position or occupancy up to 256 entries
    localparam int LKVC_CNT_W      = 9;

    localparam logic [LKVC_CAP_W-1:0] LKVC_CAP_RESET  = 5'd16;
    localparam logic [LKVC_KEY_W-1:0] LKVC_MISS_VALUE = 32'hFFFF_FFFF;

    localparam logic LKVC_OP_GET = 1'b0;
    localparam logic LKVC_OP_PUT = 1'b1;

    typedef struct packed {
        logic                   opcode;
        logic signed [31:0]     lookup_key;
        logic signed [31:0]     write_value;
    } lkvc_req_t;

    typedef struct packed {
        logic                   found;
        logic signed [31:0]     read_value;
        logic                   evicted;
        logic signed [31:0]     evicted_key;
    } lkvc_rsp_t;

    // broadcast to every cell on the commit cycle
    typedef struct packed {
        logic                   update;
        logic [LKVC_CNT_W-1:0]  limit;
        logic [LKVC_CNT_W-1:0]  occ;
    } lkvc_cell_ctrl_t;

endpackage

/* rtl/core/lru_key_value_cache_core.sv */
// lru_key_value_cache_core: fully associative key/value cache, lru replacement
// row of lkvc_cell slots in recency order with a small sequencer in front
// depends on lkvc_pkg, lkvc_cell
//
//  channel | signals                    | direction | payload
//  req     | req_valid, req_stall, req  | in        | lkvc_req_t (opcode, key, value)
//  rsp     | rsp_valid, rsp_stall, rsp  | out       | lkvc_rsp_t (found, value, eviction)
//  cfg     | cfg_write, cfg_data        | in        | capacity_in_use, 5 bits
//
// each operation runs through the states cmp, enc and upd: compare in every cell, one-hot
// encode of the hit and the last slot, then the shift of the cell row with the result load.
// the next request transfers on the commit cycle, so a new request waits for the last to commit.
// reset empties the cache and sets the capacity to 16; no clearing pass.
// a stalled result holds the commit cycle until the output register frees up.
module lru_key_value_cache_core
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = LKVC_ENTRIES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  lkvc_req_t             req,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output lkvc_rsp_t             rsp,
    input  logic                  cfg_write,
    input  logic [LKVC_CAP_W-1:0] cfg_data
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [LKVC_CNT_W-1:0] ENTRIES_C = LKVC_CNT_W'(ENTRIES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_ENC,
        ST_UPD
    } state_t;

    state_t                state_reg, state_next;
    lkvc_req_t             op_reg, op_next;
    logic [ENTRIES-1:0]    hit_reg, hit_next;
    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      hit_idx_reg, hit_idx_next;
    logic [LKVC_KEY_W-1:0] hit_value_reg, hit_value_next;
    logic                  evict_reg, evict_next;
    logic [LKVC_KEY_W-1:0] evict_key_reg, evict_key_next;
    logic [CNT_W-1:0]      occ_reg, occ_next;
    logic [LKVC_CAP_W-1:0] cap_reg, cap_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    lkvc_rsp_t             rsp_reg, rsp_next;

    logic [LKVC_KEY_W-1:0] cell_key   [ENTRIES];
    logic [LKVC_KEY_W-1:0] cell_value [ENTRIES];
    logic [ENTRIES-1:0]    cell_valid;
    logic [ENTRIES-1:0]    cell_hit;
    logic [ENTRIES-1:0]    occ_mask;

    lkvc_cell_ctrl_t       cell_ctrl;
    logic [LKVC_KEY_W-1:0] new_value;

    logic                  is_put;
    logic                  out_free;
    logic                  commit;
    logic                  accept;
    logic [LKVC_CNT_W-1:0] occ_ext;
    logic [LKVC_CNT_W-1:0] cap_ext;
    logic [LKVC_CNT_W-1:0] eff_cap;
    logic [LKVC_CNT_W-1:0] fill_count;

    assign is_put   = (op_reg.opcode == LKVC_OP_PUT);
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign commit   = (state_reg == ST_UPD) && out_free;
    assign req_stall = !((state_reg == ST_IDLE) || commit);
    assign accept   = req_valid && !req_stall;

    assign occ_ext = LKVC_CNT_W'(occ_reg);
    assign cap_ext = LKVC_CNT_W'(cap_reg);

    // capacity zero acts as one, anything above the row saturates
    always_comb
    begin
        if (cap_ext == '0)
            eff_cap = LKVC_CNT_W'(1);
        else if (cap_ext > ENTRIES_C)
            eff_cap = ENTRIES_C;
        else
            eff_cap = cap_ext;
    end

    // entries kept in front of a new insert after any eviction
    assign fill_count = occ_ext - LKVC_CNT_W'(evict_reg);

    assign new_value = is_put ? op_reg.write_value : hit_value_reg;

    always_comb
    begin
        cell_ctrl.update = commit && (found_reg || is_put);
        cell_ctrl.limit  = found_reg ? LKVC_CNT_W'(hit_idx_reg) : fill_count;
        cell_ctrl.occ    = (is_put && !found_reg) ? (fill_count + LKVC_CNT_W'(1)) : occ_ext;
    end

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++)
        begin : g_cell
            logic [LKVC_KEY_W-1:0] from_key;
            logic [LKVC_KEY_W-1:0] from_value;

            if (gi == 0)
            begin : g_head
                assign from_key   = op_reg.lookup_key;
                assign from_value = new_value;
            end
            else
            begin : g_link
                assign from_key   = cell_key[gi-1];
                assign from_value = cell_value[gi-1];
            end

            lkvc_cell #(
                .INDEX (gi)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (cell_ctrl),
                .probe_key   (op_reg.lookup_key),
                .shift_key   (from_key),
                .shift_value (from_value),
                .key         (cell_key[gi]),
                .value       (cell_value[gi]),
                .valid       (cell_valid[gi]),
                .hit         (cell_hit[gi])
            );

            assign occ_mask[gi] = (LKVC_CNT_W'(gi) < occ_ext);
        end
    endgenerate

    // one-hot encode of the registered hit vector and pick of the last slot
    always_comb
    begin
        found_next     = 1'b0;
        hit_idx_next   = '0;
        hit_value_next = '0;
        evict_key_next = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            found_next     = found_next | hit_reg[i];
            hit_idx_next   = hit_idx_next | (hit_reg[i] ? IDX_W'(i) : '0);
            hit_value_next = hit_value_next | (hit_reg[i] ? cell_value[i] : '0);
            if (LKVC_CNT_W'(i) == (occ_ext - LKVC_CNT_W'(1)))
                evict_key_next = evict_key_next | cell_key[i];
        end
        evict_next = !found_next && is_put && (occ_ext >= eff_cap) && (occ_ext != '0);
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        hit_next       = hit_reg;
        occ_next       = occ_reg;
        cap_next       = cfg_write ? cfg_data : cap_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        if (accept)
            op_next = req;

        if (!rsp_stall)
            rsp_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_CMP;
            end
            ST_CMP:
            begin
                hit_next   = cell_hit;
                state_next = ST_ENC;
            end
            ST_ENC:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (commit)
                begin
                    occ_next            = cell_ctrl.occ[CNT_W-1:0];
                    rsp_valid_next      = 1'b1;
                    rsp_next.found      = found_reg;
                    rsp_next.read_value = (found_reg && !is_put) ? hit_value_reg
                                                                 : LKVC_MISS_VALUE;
                    rsp_next.evicted    = evict_reg;
                    rsp_next.evicted_key = evict_reg ? evict_key_reg : '0;
                    state_next          = accept ? ST_CMP : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            cap_reg       <= LKVC_CAP_RESET;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            cap_reg       <= cap_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        hit_reg <= hit_next;
        if (state_reg == ST_ENC)
        begin
            found_reg     <= found_next;
            hit_idx_reg   <= hit_idx_next;
            hit_value_reg <= hit_value_next;
            evict_reg     <= evict_next;
            evict_key_reg <= evict_key_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // keys are unique among live slots, so at most one cell can hit
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ENC) |-> $onehot0(hit_reg))
    else $error("more than one slot matched the probe key");

    // live slots always form the front of the row
    assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid == occ_mask)
    else $error("slot valid bits out of step with occupancy");

    assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(ENTRIES))
    else $error("occupancy above the number of slots");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_UPD))
    else $error("result raised outside the commit cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.evicted) |-> !rsp_reg.found)
    else $error("eviction reported on a hit");

endmodule

/* rtl/core/lkvc_cell.sv */
// lkvc_cell: one recency slot of the cache, key, value and valid bit
// compares against the probe key and takes its neighbour's entry on a shift
// depends on lkvc_pkg
module lkvc_cell
    import lkvc_pkg::*;
#(
    parameter int INDEX = 0
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lkvc_cell_ctrl_t       ctrl,
    input  logic [LKVC_KEY_W-1:0] probe_key,
    input  logic [LKVC_KEY_W-1:0] shift_key,
    input  logic [LKVC_KEY_W-1:0] shift_value,
    output logic [LKVC_KEY_W-1:0] key,
    output logic [LKVC_KEY_W-1:0] value,
    output logic                  valid,
    output logic                  hit
);

    localparam logic [LKVC_CNT_W-1:0] CELL_POS = LKVC_CNT_W'(INDEX);

    logic [LKVC_KEY_W-1:0] key_reg;
    logic [LKVC_KEY_W-1:0] value_reg;
    logic                  valid_reg;
    logic                  valid_next;
    logic                  shift_en;

    // slots up to the limit move one place back, slot 0 takes the new entry
    assign shift_en   = ctrl.update && (CELL_POS <= ctrl.limit);
    assign valid_next = ctrl.update ? (CELL_POS < ctrl.occ) : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            key_reg   <= shift_key;
            value_reg <= shift_value;
        end
    end

    assign key   = key_reg;
    assign value = value_reg;
    assign valid = valid_reg;
    assign hit   = valid_reg && (key_reg == probe_key);

endmodule
